@@ rtl/dgr_pkg.sv @@
// Types, constants and helpers for the tile-grid column raycaster.
package dgr_pkg;

   localparam int MapBits     = 5;
   localparam int MapSize     = 1 << MapBits;
   localparam int MapDepth    = MapSize * MapSize;
   localparam int AddrBits    = 2 * MapBits;
   localparam int FracBits    = 16;
   localparam int ScreenRows  = 512;
   localparam int MaxSteps    = 2 * MapSize;
   localparam int DeltaBits   = 47;
   localparam int SideBits    = 54;
   localparam int DivQuoBits  = 33;
   localparam int LhBits      = 11;

   localparam logic [DeltaBits-1:0]  DeltaMax  = 47'd1 << (62 - FracBits);
   localparam logic [21:0]           DistMax   = 22'd4194303;
   localparam logic [DivQuoBits-1:0] RecipNum  = 33'd1 << (2 * FracBits);
   localparam logic [DivQuoBits-1:0] HeightNum = 33'(ScreenRows) << FracBits;
   localparam logic [LhBits-1:0]     HeightCap = 11'(2 * ScreenRows);
   localparam logic [8:0]            HalfRows  = 9'(ScreenRows / 2);
   localparam logic [8:0]            LastRow   = 9'(ScreenRows - 1);

   localparam logic [2:0] CsrPosX   = 3'd0;
   localparam logic [2:0] CsrPosY   = 3'd1;
   localparam logic [2:0] CsrDirX   = 3'd2;
   localparam logic [2:0] CsrDirY   = 3'd3;
   localparam logic [2:0] CsrPlaneX = 3'd4;
   localparam logic [2:0] CsrPlaneY = 3'd5;

   localparam logic OpWrite = 1'b0;
   localparam logic OpCast  = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [4:0] tile_x;
      logic [4:0] tile_y;
      logic [2:0] tile_value;
      logic [8:0] column;
   } req_type;

   typedef struct packed {
      logic [8:0]  column_out;
      logic [21:0] wall_dist;
      logic [8:0]  draw_start;
      logic [8:0]  draw_end;
      logic [2:0]  wall_tile;
      logic        side;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        escaped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CAM, ST_RAY, ST_DIV, ST_MLO, ST_MHI, ST_MSUM,
      ST_STEP, ST_CHECK, ST_LDIV, ST_RESP
   } state_type;

   function automatic logic [23:0] tile_rgb(input logic [2:0] tile);
      logic [23:0] rgb;
      unique case (tile)
         3'd2:    rgb = 24'h00FF00;
         3'd3:    rgb = 24'h0000FF;
         3'd4:    rgb = 24'hFF0000;
         default: rgb = 24'hFFFFFF;
      endcase
      return rgb;
   endfunction

endpackage

@@ rtl/dda_grid_raycast_column.sv @@
// Column raycaster: tile grid memory, shared divider and DDA walk sequencer.
//
//  channel   ports                               transfer when
//  req       start, busy, req_data               start high, busy low
//  rsp       rsp_strobe, rsp_data                rsp_strobe high (one cycle)
//  csr       csr_valid, csr_ready, csr_index,    csr_valid and csr_ready high
//            csr_wdata
//
// A tile write does not raise busy. A cast holds busy through the camera and ray setup,
// two reciprocal divisions, two low/high/sum multiplies for the start distances, a
// step state and a tile memory check state per grid step and, on a hit, a height
// division. An escape skips the height division. The result strobe follows the last
// busy cycle. After reset a pass clears all 1024 tile memory entries; busy stays high.
// The receiver cannot stall; each result shows for exactly one cycle.
module dda_grid_raycast_column
   import dgr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_strobe,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [20:0]   csr_wdata
);

   logic [2:0] tile_mem [MapDepth];
   logic [2:0] rd_data_ff;
   logic [AddrBits-1:0] rd_addr;

   state_type state_ff, state_in;
   logic axis_ff, axis_in;
   logic [AddrBits-1:0] clr_ff, clr_in;
   logic [20:0] pos_x_ff, pos_y_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic [8:0] column_ff, column_in;
   logic signed [35:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [18:0] mag_y_ff, mag_y_in;
   logic [DeltaBits-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SideBits-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [6:0] mx_ff, mx_in, my_ff, my_in;
   logic [6:0] n_ff, n_in;
   logic side_ff, side_in;
   logic hit_ff, hit_in;
   logic [2:0] tile_ff, tile_in;
   logic [SideBits-1:0] perp_ff, perp_in;
   logic [LhBits-1:0] lh_ff, lh_in;
   logic [SideBits-1:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [DivQuoBits-1:0] div_quo_ff, div_quo_in;
   logic [5:0] div_cnt_ff, div_cnt_in;
   logic [33:0] plo_ff, plo_in;
   logic [46:0] phi_ff, phi_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept;
   logic signed [17:0] cam;
   logic signed [20:0] rx_w, ry_w;
   logic [18:0] mag_x_w;
   logic [SideBits:0] div_shift, div_diff;
   logic div_ge;
   logic [SideBits-1:0] div_rem_step;
   logic [DivQuoBits-1:0] div_quo_step;
   logic [16:0] frac_f;
   logic [DeltaBits-1:0] mul_d;
   logic [63:0] mul_sum;
   logic [SideBits-1:0] sx_step, sy_step;
   logic [6:0] mx_step, my_step;
   logic step_x, in_grid;
   logic [9:0] half_lh;
   logic [23:0] rgb;

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         tile_mem[clr_ff] <= 3'd0;
      end else if (accept && req_data.opcode == OpWrite) begin
         tile_mem[{req_data.tile_x, req_data.tile_y}] <= req_data.tile_value;
      end
      rd_data_ff <= tile_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= 21'd786432;
         pos_y_ff   <= 21'd786432;
         dir_x_ff   <= -18'sd65536;
         dir_y_ff   <= 18'sd0;
         plane_x_ff <= 18'sd0;
         plane_y_ff <= -18'sd43254;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrPosX:   pos_x_ff   <= csr_wdata;
            CsrPosY:   pos_y_ff   <= csr_wdata;
            CsrDirX:   dir_x_ff   <= $signed(csr_wdata[17:0]);
            CsrDirY:   dir_y_ff   <= $signed(csr_wdata[17:0]);
            CsrPlaneX: plane_x_ff <= $signed(csr_wdata[17:0]);
            CsrPlaneY: plane_y_ff <= $signed(csr_wdata[17:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff    <= axis_in;
      column_ff  <= column_in;
      prod_x_ff  <= prod_x_in;
      prod_y_ff  <= prod_y_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      mag_y_ff   <= mag_y_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      n_ff       <= n_in;
      side_ff    <= side_in;
      hit_ff     <= hit_in;
      tile_ff    <= tile_in;
      perp_ff    <= perp_in;
      lh_ff      <= lh_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_quo_ff <= div_quo_in;
      div_cnt_ff <= div_cnt_in;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      cam  = $signed({1'b0, column_ff, 8'd0}) - 18'sd65536;
      rx_w = 21'(dir_x_ff) + 21'(prod_x_ff >>> FracBits);
      ry_w = 21'(dir_y_ff) + 21'(prod_y_ff >>> FracBits);
      mag_x_w = rx_w[20] ? 19'(-rx_w) : rx_w[18:0];

      div_shift    = {div_rem_ff, div_quo_ff[DivQuoBits-1]};
      div_diff     = div_shift - {1'b0, div_den_ff};
      div_ge       = div_shift >= {1'b0, div_den_ff};
      div_rem_step = div_ge ? div_diff[SideBits-1:0] : div_shift[SideBits-1:0];
      div_quo_step = {div_quo_ff[DivQuoBits-2:0], div_ge};

      mul_d  = axis_ff ? dy_ff : dx_ff;
      if (axis_ff) begin
         frac_f = neg_y_ff ? {1'b0, pos_y_ff[15:0]} : 17'h10000 - {1'b0, pos_y_ff[15:0]};
      end else begin
         frac_f = neg_x_ff ? {1'b0, pos_x_ff[15:0]} : 17'h10000 - {1'b0, pos_x_ff[15:0]};
      end
      mul_sum = {phi_ff, 17'd0} + 64'(plo_ff);

      step_x  = sx_ff < sy_ff;
      sx_step = sx_ff + SideBits'(dx_ff);
      sy_step = sy_ff + SideBits'(dy_ff);
      mx_step = step_x ? (neg_x_ff ? mx_ff - 7'd1 : mx_ff + 7'd1) : mx_ff;
      my_step = step_x ? my_ff : (neg_y_ff ? my_ff - 7'd1 : my_ff + 7'd1);
      in_grid = mx_step[6:5] == 2'b00 && my_step[6:5] == 2'b00;
      rd_addr = {mx_step[4:0], my_step[4:0]};

      half_lh = lh_ff[10:1];
      rgb     = tile_rgb(tile_ff);
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      axis_in      = axis_ff;
      column_in    = column_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      mag_y_in     = mag_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      n_in         = n_ff;
      side_in      = side_ff;
      hit_in       = hit_ff;
      tile_in      = tile_ff;
      perp_in      = perp_ff;
      lh_in        = lh_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_quo_in   = div_quo_ff;
      div_cnt_in   = div_cnt_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AddrBits'(MapDepth - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_data.opcode == OpCast) begin
               column_in = req_data.column;
               state_in  = ST_CAM;
            end
         end
         ST_CAM: begin
            prod_x_in = plane_x_ff * cam;
            prod_y_in = plane_y_ff * cam;
            state_in  = ST_RAY;
         end
         ST_RAY: begin
            neg_x_in   = rx_w[20];
            neg_y_in   = ry_w[20];
            mag_y_in   = ry_w[20] ? 19'(-ry_w) : ry_w[18:0];
            div_den_in = SideBits'(mag_x_w);
            div_rem_in = '0;
            div_quo_in = RecipNum;
            div_cnt_in = '0;
            axis_in    = 1'b0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'(DivQuoBits - 1)) begin
               if (axis_ff) begin
                  dy_in    = (div_den_ff == '0) ? DeltaMax : DeltaBits'(div_quo_step);
                  axis_in  = 1'b0;
                  state_in = ST_MLO;
               end else begin
                  dx_in      = (div_den_ff == '0) ? DeltaMax : DeltaBits'(div_quo_step);
                  div_den_in = SideBits'(mag_y_ff);
                  div_rem_in = '0;
                  div_quo_in = RecipNum;
                  div_cnt_in = '0;
                  axis_in    = 1'b1;
               end
            end
         end
         ST_MLO: begin
            plo_in   = frac_f * mul_d[16:0];
            state_in = ST_MHI;
         end
         ST_MHI: begin
            phi_in   = frac_f * mul_d[46:17];
            state_in = ST_MSUM;
         end
         ST_MSUM: begin
            if (axis_ff) begin
               sy_in    = SideBits'(mul_sum[63:16]);
               mx_in    = {2'b00, pos_x_ff[20:16]};
               my_in    = {2'b00, pos_y_ff[20:16]};
               n_in     = '0;
               state_in = ST_STEP;
            end else begin
               sx_in    = SideBits'(mul_sum[63:16]);
               axis_in  = 1'b1;
               state_in = ST_MLO;
            end
         end
         ST_STEP: begin
            if (step_x) begin
               sx_in = sx_step;
            end else begin
               sy_in = sy_step;
            end
            mx_in   = mx_step;
            my_in   = my_step;
            side_in = !step_x;
            n_in    = n_ff + 7'd1;
            if (in_grid) begin
               state_in = ST_CHECK;
            end else begin
               hit_in   = 1'b0;
               state_in = ST_RESP;
            end
         end
         ST_CHECK: begin
            if (rd_data_ff != 3'd0) begin
               hit_in     = 1'b1;
               tile_in    = rd_data_ff;
               perp_in    = side_ff ? sy_ff - SideBits'(dy_ff) : sx_ff - SideBits'(dx_ff);
               div_den_in = side_ff ? sy_ff - SideBits'(dy_ff) : sx_ff - SideBits'(dx_ff);
               div_rem_in = '0;
               div_quo_in = HeightNum;
               div_cnt_in = '0;
               state_in   = ST_LDIV;
            end else if (n_ff == 7'(MaxSteps)) begin
               hit_in   = 1'b0;
               state_in = ST_RESP;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_LDIV: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'(DivQuoBits - 1)) begin
               if (perp_ff == '0 || div_quo_step > DivQuoBits'(HeightCap)) begin
                  lh_in = HeightCap;
               end else begin
                  lh_in = div_quo_step[LhBits-1:0];
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid_in      = 1'b1;
            rsp_in.column_out = column_ff;
            rsp_in.side       = side_ff;
            if (hit_ff) begin
               rsp_in.wall_dist  = (perp_ff > SideBits'(DistMax)) ? DistMax : perp_ff[21:0];
               rsp_in.draw_start = (half_lh >= 10'(HalfRows)) ? 9'd0
                                   : HalfRows - half_lh[8:0];
               rsp_in.draw_end   = (half_lh + 10'(HalfRows) > 10'(LastRow)) ? LastRow
                                   : 9'(half_lh + 10'(HalfRows));
               rsp_in.wall_tile  = tile_ff;
               rsp_in.red        = side_ff ? {1'b0, rgb[23:17]} : rgb[23:16];
               rsp_in.green      = side_ff ? {1'b0, rgb[15:9]}  : rgb[15:8];
               rsp_in.blue       = side_ff ? {1'b0, rgb[7:1]}   : rgb[7:0];
               rsp_in.escaped    = 1'b0;
            end else begin
               rsp_in.wall_dist  = DistMax;
               rsp_in.draw_start = HalfRows;
               rsp_in.draw_end   = HalfRows;
               rsp_in.wall_tile  = 3'd0;
               rsp_in.red        = 8'd0;
               rsp_in.green      = 8'd0;
               rsp_in.blue       = 8'd0;
               rsp_in.escaped    = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.opcode == OpCast |=> busy)
      else $error("cast not held busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_check_after_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> $past(state_ff) == ST_STEP)
      else $error("tile check without a grid step");

   a_escape_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.escaped |-> rsp_data.wall_tile == 3'd0 && !hit_ff)
      else $error("escaped result carries a tile");

endmodule

@@ tb/sv/dda_grid_raycast_column_tb.sv @@
// Testbench for the tile-grid column raycaster: random tile writes, casts and camera updates.
`timescale 1ns / 1ps

module dda_grid_raycast_column_tb;
   import dgr_pkg::*;

   localparam int SettleCycles = 300;
   localparam int PhaseCount   = 24;
   localparam int PhaseItems   = 60;

   typedef struct {
      bit          is_csr;
      logic [2:0]  index;
      logic [20:0] wdata;
      req_type     req;
   } cmd_entry_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [2:0]  csr_index;
   logic [20:0] csr_wdata;

   cmd_entry_type pending_q[$];
   rsp_type  column_q[$];

   logic [2:0] grid [MapDepth];
   longint unsigned cam_pos_x, cam_pos_y;
   longint cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;

   int errors;
   int gap;
   int quiet;
   int burst_left;

   dda_grid_raycast_column dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic longint sext18(input logic [20:0] v);
      return longint'(signed'(v[17:0]));
   endfunction

   task automatic camera_write(input logic [2:0] index, input logic [20:0] value);
      case (index)
         CsrPosX:   cam_pos_x = value;
         CsrPosY:   cam_pos_y = value;
         CsrDirX:   cam_dir_x = sext18(value);
         CsrDirY:   cam_dir_y = sext18(value);
         CsrPlaneX: cam_plane_x = sext18(value);
         CsrPlaneY: cam_plane_y = sext18(value);
         default: ;
      endcase
   endtask

   function automatic longint unsigned inv_len(input longint r);
      longint unsigned a, d;
      if (r == 0) return longint'(DeltaMax);
      a = (r < 0) ? -r : r;
      d = (64'd1 << (2 * FracBits)) / a;
      return (d > DeltaMax) ? longint'(DeltaMax) : d;
   endfunction

   task automatic predict_column(input req_type req);
      longint cam, rx, ry, mx, my, sgx, sgy, ds, de;
      longint unsigned dx, dy, sx, sy, perp, lh, fx, fy;
      logic [2:0] tile;
      logic [23:0] rgb;
      bit hit, side;
      rsp_type r;
      if (req.opcode == OpWrite) begin
         grid[{req.tile_x, req.tile_y}] = req.tile_value;
         return;
      end
      hit = 0;
      side = 0;
      tile = 0;
      cam = longint'(((64'(req.column) * 2) << FracBits) / 512) - (64'd1 << FracBits);
      rx = cam_dir_x + ((cam_plane_x * cam) >>> FracBits);
      ry = cam_dir_y + ((cam_plane_y * cam) >>> FracBits);
      mx = cam_pos_x >> FracBits;
      my = cam_pos_y >> FracBits;
      dx = inv_len(rx);
      dy = inv_len(ry);
      fx = cam_pos_x & 64'hFFFF;
      fy = cam_pos_y & 64'hFFFF;
      sgx = (rx < 0) ? -1 : 1;
      sgy = (ry < 0) ? -1 : 1;
      sx = (((rx < 0) ? fx : (64'd65536 - fx)) * dx) >> FracBits;
      sy = (((ry < 0) ? fy : (64'd65536 - fy)) * dy) >> FracBits;
      for (int n = 0; n < MaxSteps; n++) begin
         if (sx < sy) begin
            sx += dx;
            mx += sgx;
            side = 0;
         end else begin
            sy += dy;
            my += sgy;
            side = 1;
         end
         if (mx < 0 || mx >= MapSize || my < 0 || my >= MapSize) break;
         tile = grid[{mx[4:0], my[4:0]}];
         if (tile != 0) begin
            hit = 1;
            break;
         end
      end
      r = '0;
      r.column_out = req.column;
      r.side = side;
      if (!hit) begin
         r.wall_dist = DistMax;
         r.draw_start = HalfRows;
         r.draw_end = HalfRows;
         r.escaped = 1'b1;
      end else begin
         perp = side ? sy - dy : sx - dx;
         if (perp == 0) begin
            lh = 2 * ScreenRows;
         end else begin
            lh = (64'(ScreenRows) << FracBits) / perp;
            if (lh > 2 * ScreenRows) lh = 2 * ScreenRows;
         end
         ds = ScreenRows / 2 - longint'(lh / 2);
         if (ds < 0) ds = 0;
         de = longint'(lh / 2) + ScreenRows / 2;
         if (de >= ScreenRows) de = ScreenRows - 1;
         case (tile)
            3'd2:    rgb = 24'h00FF00;
            3'd3:    rgb = 24'h0000FF;
            3'd4:    rgb = 24'hFF0000;
            default: rgb = 24'hFFFFFF;
         endcase
         r.wall_dist = (perp > DistMax) ? DistMax : perp[21:0];
         r.draw_start = ds[8:0];
         r.draw_end = de[8:0];
         r.wall_tile = tile;
         r.red = side ? rgb[23:16] >> 1 : rgb[23:16];
         r.green = side ? rgb[15:8] >> 1 : rgb[15:8];
         r.blue = side ? rgb[7:0] >> 1 : rgb[7:0];
      end
      column_q.push_back(r);
   endtask

   function automatic int pick_gap();
      int p;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      p = $urandom_range(0, 99);
      if (p < 3) burst_left = $urandom_range(20, 80);
      if (p < 70) return $urandom_range(0, 2);
      if (p < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         csr_valid <= 1'b0;
         csr_index <= CsrPosX;
         csr_wdata <= '0;
         gap = 0;
         quiet = 0;
         burst_left = 0;
      end else begin
         if (start && !busy) begin
            predict_column(req_data);
            gap = pick_gap();
         end
         if (csr_valid && csr_ready) begin
            camera_write(csr_index, csr_wdata);
            gap = pick_gap();
         end
         if (column_q.size() == 0 && !busy && !start) quiet++;
         else quiet = 0;
         if ((start && busy) || (csr_valid && !csr_ready)) begin
            // hold until transfer
         end else if (gap > 0) begin
            gap--;
            start <= 1'b0;
            csr_valid <= 1'b0;
         end else if (pending_q.size() > 0 && !pending_q[0].is_csr) begin
            req_data <= pending_q[0].req;
            start <= 1'b1;
            csr_valid <= 1'b0;
            void'(pending_q.pop_front());
         end else if (pending_q.size() > 0 && column_q.size() == 0 && quiet >= SettleCycles)
         begin
            csr_index <= pending_q[0].index;
            csr_wdata <= pending_q[0].wdata;
            csr_valid <= 1'b1;
            start <= 1'b0;
            void'(pending_q.pop_front());
         end else begin
            start <= 1'b0;
            csr_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string what, input longint got, input longint want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (column_q.size() == 0) begin
            report_mismatch("unexpected column", rsp_data.column_out, -1);
         end else begin
            e = column_q.pop_front();
            check_field("column_out", rsp_data.column_out, e.column_out);
            check_field("wall_dist", rsp_data.wall_dist, e.wall_dist);
            check_field("draw_start", rsp_data.draw_start, e.draw_start);
            check_field("draw_end", rsp_data.draw_end, e.draw_end);
            check_field("wall_tile", rsp_data.wall_tile, e.wall_tile);
            check_field("side", rsp_data.side, e.side);
            check_field("red", rsp_data.red, e.red);
            check_field("green", rsp_data.green, e.green);
            check_field("blue", rsp_data.blue, e.blue);
            check_field("escaped", rsp_data.escaped, e.escaped);
         end
      end
   end

   task automatic add_write(input int x, input int y, input int v);
      cmd_entry_type c;
      c = '{default: '0};
      c.req.opcode = OpWrite;
      c.req.tile_x = 5'(x);
      c.req.tile_y = 5'(y);
      c.req.tile_value = 3'(v);
      c.req.column = 9'($urandom);
      pending_q.push_back(c);
   endtask

   task automatic add_cast(input int col);
      cmd_entry_type c;
      c = '{default: '0};
      c.req.opcode = OpCast;
      c.req.column = 9'(col);
      c.req.tile_x = 5'($urandom);
      c.req.tile_y = 5'($urandom);
      c.req.tile_value = 3'($urandom);
      pending_q.push_back(c);
   endtask

   task automatic add_csr(input logic [2:0] index, input logic [20:0] value);
      cmd_entry_type c;
      c = '{default: '0};
      c.is_csr = 1'b1;
      c.index = index;
      c.wdata = value;
      pending_q.push_back(c);
   endtask

   function automatic logic [20:0] camera_value(input logic [2:0] index);
      int p;
      p = $urandom_range(0, 9);
      if (index == CsrPosX || index == CsrPosY) begin
         if (p == 0) return 21'd0;
         if (p == 1) return 21'h1FFFFF;
         return 21'($urandom);
      end
      if (p == 0) return 21'h020000;
      if (p == 1) return 21'h01FFFF;
      if (p == 2) return 21'h1E0000 | 21'($urandom_range(0, 131071));
      return 21'($urandom);
   endfunction

   initial begin
      logic [2:0] ix;
      errors = 0;
      reset = 1'b1;
      cam_pos_x = 64'd12 << FracBits;
      cam_pos_y = 64'd12 << FracBits;
      cam_dir_x = -65536;
      cam_dir_y = 0;
      cam_plane_x = 0;
      cam_plane_y = -43254;
      foreach (grid[i]) grid[i] = '0;

      add_cast(0);
      add_cast(256);
      add_cast(511);
      add_write(11, 12, 1);
      add_cast(256);
      add_cast(0);
      add_cast(511);
      add_write(11, 12, 0);
      add_write(0, 12, 2);
      add_write(6, 0, 3);
      add_write(31, 31, 4);
      add_write(0, 0, 5);
      add_write(3, 31, 6);
      add_write(31, 3, 7);
      add_cast(256);
      add_cast(100);
      add_cast(400);
      add_csr(CsrPosX, 21'h1FFFFF);
      add_csr(CsrPosY, 21'd0);
      add_csr(CsrDirX, 21'h01FFFF);
      add_csr(CsrDirY, 21'h020000);
      add_csr(CsrPlaneX, 21'h020000);
      add_csr(CsrPlaneY, 21'h01FFFF);
      add_csr(CsrPlaneY + 3'd1, 21'($urandom));
      add_cast(0);
      add_cast(511);
      add_write(31, 31, 0);
      add_cast(300);

      for (int ph = 0; ph < PhaseCount; ph++) begin
         for (int k = 0; k < 6; k++)
            if (ph == 0 || $urandom_range(0, 2) != 0) add_csr(3'(k), camera_value(3'(k)));
         if ($urandom_range(0, 3) == 0) begin
            ix = 3'($urandom_range(0, 1));
            add_csr(CsrPlaneY + 3'd1 + ix, 21'($urandom));
         end
         for (int n = 0; n < PhaseItems; n++) begin
            if ($urandom_range(0, 9) < 7) begin
               add_cast($urandom_range(0, 511));
            end else if ($urandom_range(0, 2) == 0) begin
               case ($urandom_range(0, 3))
                  0: add_write(0, $urandom_range(0, 31), $urandom_range(1, 7));
                  1: add_write(31, $urandom_range(0, 31), $urandom_range(1, 7));
                  2: add_write($urandom_range(0, 31), 0, $urandom_range(1, 7));
                  default: add_write($urandom_range(0, 31), 31, $urandom_range(1, 7));
               endcase
            end else begin
               add_write($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 7));
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_q.size() > 0 || start || csr_valid || column_q.size() > 0);
      repeat (SettleCycles) @(posedge clock);
      if (errors == 0) $display("dda_grid_raycast_column test passed");
      else $display("dda_grid_raycast_column test failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("dda_grid_raycast_column test failed");
      $finish;
   end

endmodule
